[rtl/ltsz_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ltsz_pkg
// Shared constants and control types of the leaky threshold spike zone.
// ----------------------------------------------------------------------------
package ltsz_pkg;

	localparam int MAX_ONSETS_DEF = 32;

	// configuration register indexes
	localparam logic [2:0] REG_INTEG   = 3'd0;
	localparam logic [2:0] REG_STAB    = 3'd1;
	localparam logic [2:0] REG_GAIN    = 3'd2;
	localparam logic [2:0] REG_THR_ON  = 3'd3;
	localparam logic [2:0] REG_THR_OFF = 3'd4;
	localparam logic [2:0] REG_AMP     = 3'd5;
	localparam logic [2:0] REG_WINDOW  = 3'd6;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // take input word, register integrator difference
		logic mul_go;    // integrator update from the gain product
		logic fire;      // threshold compare, onset write
		logic scan_init; // start prune pass
		logic scan_step; // move one ring entry
		logic fin;       // commit prune results
		logic div_init;  // start rate divide
		logic div_step;  // one quotient bit
		logic div_fin;   // commit rate
		logic out_load;  // load output register
	} ltsz_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic scan_done;
		logic do_div;
		logic div_done;
	} ltsz_sts_t;

endpackage
`default_nettype wire

[rtl/leaky_threshold_spike_zone.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// leaky_threshold_spike_zone
// Leaky integrate threshold zone with onset ring and rate estimate.
// ----------------------------------------------------------------------------
// One input word is one tick. The block takes a word only when idle and is
// busy with it until its result is loaded, longer when the result side
// stalls. The prune pass walks the onset ring one entry a cycle through its
// read port, and the rate comes from a serial divider of fill width + 16
// steps (22 at the default depth), where fill is the onset count.
// It takes the next word once its result sits in the output register.
module leaky_threshold_spike_zone #(
	parameter int MAX_ONSETS = ltsz_pkg::MAX_ONSETS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] neural_potential,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pulse_level,
	output logic signed [31:0]      zone_potential,
	output logic [15:0]             pulse_rate,
	output logic [5:0]              onsets_in_window,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import ltsz_pkg::*;

	ltsz_cmd_t cmd;
	ltsz_sts_t sts;

	logic               integ_q, stab_q;
	logic [17:0]        gain_q;
	logic signed [31:0] thr_on_q, thr_off_q, amp_q;
	logic [31:0]        window_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= 1'b1;
			stab_q <= 1'b1;
			gain_q <= 18'd16384;
			thr_on_q <= 32'sd1;
			thr_off_q <= '0;
			amp_q <= 32'sd65536;
			window_q <= 32'd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INTEG:   integ_q <= cfg_data[0];
				REG_STAB:    stab_q <= cfg_data[0];
				REG_GAIN:    gain_q <= cfg_data[17:0];
				REG_THR_ON:  thr_on_q <= cfg_data;
				REG_THR_OFF: thr_off_q <= cfg_data;
				REG_AMP:     amp_q <= cfg_data;
				REG_WINDOW:  window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	ltsz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_busy (out_valid && out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ltsz_dp #(.MAX_ONSETS(MAX_ONSETS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (neural_potential),
		.cfg_integ   (integ_q),
		.cfg_stab    (stab_q),
		.cfg_gain    (gain_q),
		.cfg_thr_on  (thr_on_q),
		.cfg_thr_off (thr_off_q),
		.cfg_amp     (amp_q),
		.cfg_window  (window_q),
		.res_pulse   (pulse_level),
		.res_pot     (zone_potential),
		.res_rate    (pulse_rate),
		.res_fill    (onsets_in_window)
	);

endmodule
`default_nettype wire

[rtl/ltsz_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ltsz_ctrl
// Sequencer: integrate, fire, prune scan, serial rate divide, output.
// ----------------------------------------------------------------------------
module ltsz_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             out_busy,
	input  wire ltsz_pkg::ltsz_sts_t sts,
	output ltsz_pkg::ltsz_cmd_t   cmd
);
	import ltsz_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_FIRE = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_go = 1'b1;
				state_d = S_FIRE;
			end
			S_FIRE: begin
				cmd.fire = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_FIN;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				if (sts.do_div) begin
					cmd.div_init = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.div_fin = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_OUT: begin
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_FIRE) cmd.scan_init = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

[rtl/ltsz_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ltsz_dp
// Datapath: integrator, pulse logic, onset ring with prune, serial divider.
// ----------------------------------------------------------------------------
module ltsz_dp #(
	parameter int MAX_ONSETS = ltsz_pkg::MAX_ONSETS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ltsz_pkg::ltsz_cmd_t cmd,
	output ltsz_pkg::ltsz_sts_t     sts,
	input  wire logic signed [31:0] sample,
	input  wire logic               cfg_integ,
	input  wire logic               cfg_stab,
	input  wire logic [17:0]        cfg_gain,
	input  wire logic signed [31:0] cfg_thr_on,
	input  wire logic signed [31:0] cfg_thr_off,
	input  wire logic signed [31:0] cfg_amp,
	input  wire logic [31:0]        cfg_window,
	output logic signed [31:0]      res_pulse,
	output logic signed [31:0]      res_pot,
	output logic [15:0]             res_rate,
	output logic [5:0]              res_fill
);
	import ltsz_pkg::*;

	localparam int AW = $clog2(MAX_ONSETS);
	localparam int FW = $clog2(MAX_ONSETS + 1);
	// divide numerator is count << 16
	localparam int NW = FW + 16;

	logic signed [31:0] filt_q, hold_q;
	logic               firing_q;
	logic [31:0]        tick_q, now_q;
	logic [AW-1:0]      head_q;
	logic [FW-1:0]      fill_q;
	logic [15:0]        rate_q;
	logic signed [33:0] diff_q;

	logic [31:0]        ring_mem [MAX_ONSETS];

	// integrator drive and difference
	logic signed [33:0] drive;
	always_comb begin
		drive = '0;
		if (cfg_stab) drive = (hold_q > 0) ? -34'(cfg_thr_on) : 34'(sample);
	end

	// product, floor by 2^16 is an arithmetic shift
	logic signed [52:0] mul_w;
	logic signed [36:0] sum_w;
	logic signed [31:0] filt_new;
	assign mul_w = 53'(diff_q) * $signed({35'd0, cfg_gain});
	assign sum_w = 37'(filt_q) + 37'(mul_w >>> 16);
	always_comb begin
		if (sum_w > 37'sd2147483647) filt_new = 32'sh7fffffff;
		else if (sum_w < -37'sd2147483648) filt_new = 32'sh80000000;
		else filt_new = sum_w[31:0];
	end

	// scan and divide state
	logic [FW-1:0] rd_q, wr_q, scan_n_q;
	logic [31:0]   first_q, last_q;
	logic          scanning_q, rd_v_q;
	logic          scan_arm_q;
	logic [31:0]   rdata_s1;
	logic [AW-1:0] rd_idx;
	logic [FW:0]   rd_sum;
	logic          pruning_q;
	logic [31:0]   age;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] num_q;
	logic [15:0]   quo_q;
	logic [4:0]    dcnt_q;
	logic [31:0]   span_q;
	logic          sat_q;

	assign rd_sum = (FW+1)'(head_q) + (FW+1)'(rd_q);
	assign rd_idx = (rd_sum >= (FW+1)'(MAX_ONSETS)) ?
		AW'(rd_sum - (FW+1)'(MAX_ONSETS)) : AW'(rd_sum);
	assign age = now_q - rdata_s1;

	assign sts.scan_done = !scan_arm_q && (!pruning_q || (!scanning_q && !rd_v_q));
	assign sts.do_div = pruning_q && (wr_q > FW'(2)) && (last_q != first_q);
	assign sts.div_done = (dcnt_q == 5'd0);

	// ring write address for an onset
	logic [FW:0]   wsum;
	logic [AW-1:0] widx;
	assign wsum = (FW+1)'(head_q) + (FW+1)'(fill_q);
	assign widx = (fill_q >= FW'(MAX_ONSETS)) ? head_q :
		((wsum >= (FW+1)'(MAX_ONSETS)) ? AW'(wsum - (FW+1)'(MAX_ONSETS)) : AW'(wsum));

	// compaction address: kept entries stay in ring order from head
	logic [FW:0]   ksum;
	logic [AW-1:0] kidx;
	assign ksum = (FW+1)'(head_q) + (FW+1)'(wr_q);
	assign kidx = (ksum >= (FW+1)'(MAX_ONSETS)) ?
		AW'(ksum - (FW+1)'(MAX_ONSETS)) : AW'(ksum);

	// restoring divide step
	logic [NW:0] trial;
	assign trial = {rem_q, num_q[NW-1]};

	// ring memory: one write port, one registered read
	logic          fire_on;
	logic          keep;
	assign fire_on = (filt_q >= cfg_thr_on) && !firing_q;
	assign keep = rd_v_q && (age <= cfg_window);
	always_ff @(posedge clk) begin
		if (cmd.fire && fire_on) ring_mem[widx] <= now_q;
		else if (keep) ring_mem[kidx] <= rdata_s1;
		rdata_s1 <= ring_mem[rd_idx];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			diff_q <= drive - 34'(filt_q);
			now_q <= tick_q;
		end
		if (keep) begin
			if (wr_q == '0) first_q <= rdata_s1;
			last_q <= rdata_s1;
		end
		if (cmd.div_init) begin
			span_q <= last_q - first_q;
			num_q <= {wr_q, 16'd0};
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (32'(trial) >= span_q) begin
				rem_q <= NW'(trial - span_q[NW:0]);
				if (quo_q[15]) sat_q <= 1'b1;
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= trial[NW-1:0];
				if (quo_q[15]) sat_q <= 1'b1;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			res_pulse <= hold_q;
			res_pot <= filt_q;
			res_rate <= rate_q;
			res_fill <= 6'(fill_q);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
			hold_q <= '0;
			firing_q <= 1'b0;
			tick_q <= '0;
			head_q <= '0;
			fill_q <= '0;
			rate_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			scan_n_q <= '0;
			scanning_q <= 1'b0;
			rd_v_q <= 1'b0;
			scan_arm_q <= 1'b0;
			pruning_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (cmd.load) begin
				tick_q <= tick_q + 32'd1;
				if (!cfg_integ) filt_q <= sample;
			end
			if (cmd.mul_go && cfg_integ) filt_q <= filt_new;
			if (cmd.fire) begin
				if (filt_q >= cfg_thr_on) begin
					hold_q <= cfg_amp;
					firing_q <= 1'b1;
					if (!firing_q) begin
						if (fill_q >= FW'(MAX_ONSETS))
							head_q <= (head_q == AW'(MAX_ONSETS - 1)) ? '0 : head_q + 1'b1;
						else fill_q <= fill_q + 1'b1;
					end
				end else if (filt_q < cfg_thr_off) begin
					hold_q <= '0;
					firing_q <= 1'b0;
				end
			end
			// prune pass: read, then compact kept entries toward head
			if (cmd.scan_init) begin
				rd_q <= '0;
				wr_q <= '0;
				rd_v_q <= 1'b0;
				scanning_q <= 1'b0;
				pruning_q <= 1'b0;
				scan_arm_q <= 1'b1;
			end
			if (cmd.scan_step) begin
				if (scan_arm_q) begin
					// first step latches the post-onset fill
					scan_arm_q <= 1'b0;
					pruning_q <= (fill_q > FW'(1));
					scanning_q <= (fill_q > FW'(1));
					scan_n_q <= fill_q;
				end else begin
					rd_v_q <= scanning_q;
					if (scanning_q) begin
						if (rd_q == scan_n_q - 1'b1) scanning_q <= 1'b0;
						rd_q <= rd_q + 1'b1;
					end
					if (keep) wr_q <= wr_q + 1'b1;
				end
			end
			if (cmd.fin) begin
				scan_n_q <= '0;
				if (pruning_q) begin
					fill_q <= wr_q;
					if (wr_q <= FW'(2)) rate_q <= '0;
				end else begin
					rate_q <= '0;
				end
			end
			if (cmd.div_init) dcnt_q <= 5'(NW);
			else if (cmd.div_step) dcnt_q <= dcnt_q - 1'b1;
			if (cmd.div_fin) rate_q <= sat_q ? 16'hffff : quo_q;
		end
	end

endmodule
`default_nettype wire
